// ===== design/dc_blocked_envelope_follower_macros.svh =====
// Assertion macros for the envelope follower design.
`ifndef DC_BLOCKED_ENVELOPE_FOLLOWER_MACROS_SVH
`define DC_BLOCKED_ENVELOPE_FOLLOWER_MACROS_SVH

// Condition holds at every clock edge outside reset.
`define DCBEF_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define DCBEF_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define DCBEF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/dcbef_pkg.sv =====
// Widths, constants and shared types of the DC-blocked envelope follower.
package dcbef_pkg;

	localparam int SAMPLE_WIDTH = 16;
	localparam int FRAC         = SAMPLE_WIDTH - 1;
	localparam int DC_WIDTH     = FRAC + 3;
	localparam int ENV_WIDTH    = FRAC + 2;
	localparam int SUM_WIDTH    = DC_WIDTH + 1;

	localparam int COEF_WIDTH  = 16;
	localparam int GAIN_WIDTH  = 16;
	localparam int LEVEL_WIDTH = 15;
	localparam int MOD_WIDTH   = 16;

	localparam int MUL_A_WIDTH = (DC_WIDTH > GAIN_WIDTH) ? DC_WIDTH : GAIN_WIDTH;
	localparam int MUL_B_WIDTH = COEF_WIDTH + 1;
	localparam int PROD_WIDTH  = MUL_A_WIDTH + MUL_B_WIDTH;

	localparam int POLE_Q16    = 65208;
	localparam int POLE_SHIFT  = 16;
	localparam int COEF_SHIFT  = 16;
	localparam int GAIN_SHIFT  = 15;
	localparam int LEVEL_SCALE = 10;
	localparam int LEVEL_MAX   = 20480;
	localparam int LEVEL_FRAC  = 11;
	localparam int LVL_RSH     = (FRAC > LEVEL_FRAC) ? FRAC - LEVEL_FRAC : 0;
	localparam int LVL_LSH     = (FRAC > LEVEL_FRAC) ? 0 : LEVEL_FRAC - FRAC;

	localparam int CFG_INDEX_WIDTH = 2;
	localparam int CFG_DATA_WIDTH  = 16;

	localparam logic [CFG_INDEX_WIDTH-1:0] REG_ATTACK_COEF  = 2'd0;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_RELEASE_COEF = 2'd1;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_GAIN         = 2'd2;

	typedef struct packed {
		logic                          en;
		logic signed [MUL_A_WIDTH-1:0] a;
		logic signed [MUL_B_WIDTH-1:0] b;
	} mul_req_t;

endpackage

// ===== design/dcbef_mul.sv =====
// Shared signed multiplier with a registered product.
module dcbef_mul (
	input  logic                                     clk,
	input  dcbef_pkg::mul_req_t                      req,
	output logic signed [dcbef_pkg::PROD_WIDTH-1:0] prod_q
);
	import dcbef_pkg::*;

	always_ff @(posedge clk) begin
		if (req.en) begin
			prod_q <= req.a * req.b;
		end
	end

endmodule

// ===== design/dc_blocked_envelope_follower.sv =====
// envelope_level and modulation_amount are registered in EMIT once the output register is free.
// A new sample is taken only after the last result has left EMIT; the one shared multiplier runs four products
// (pole, follower, scale by ten, gain), each registered and then consumed in its own step.
// sample_ready is high only while the sequencer is idle; a held result stalls it.
// Reset clears the blocker and follower state and all three registers to zero.
`include "dc_blocked_envelope_follower_macros.svh"

module dc_blocked_envelope_follower (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          cfg_we,
	input  logic [dcbef_pkg::CFG_INDEX_WIDTH-1:0]         cfg_index,
	input  logic [dcbef_pkg::CFG_DATA_WIDTH-1:0]          cfg_wdata,
	input  logic                                          sample_valid,
	output logic                                          sample_ready,
	input  logic signed [dcbef_pkg::SAMPLE_WIDTH-1:0]     sample_in,
	output logic                                          out_valid,
	input  logic                                          out_ready,
	output logic [dcbef_pkg::LEVEL_WIDTH-1:0]             envelope_level,
	output logic signed [dcbef_pkg::MOD_WIDTH-1:0]        modulation_amount
);
	import dcbef_pkg::*;

	typedef enum logic [3:0] {
		IDLE,
		MUL_POLE,
		BLOCK,
		MUL_ENV,
		ENV,
		MUL_LVL,
		LEVEL,
		MUL_GAIN,
		EMIT
	} state_t;

	localparam logic signed [SUM_WIDTH-1:0] SUM_POS = SUM_WIDTH'(2 ** (FRAC + 1));
	localparam logic signed [SUM_WIDTH-1:0] SUM_NEG = -SUM_POS;
	localparam logic signed [DC_WIDTH-1:0]  DC_POS  = DC_WIDTH'(2 ** (FRAC + 1));
	localparam logic signed [DC_WIDTH-1:0]  DC_NEG  = -DC_POS;
	localparam logic [ENV_WIDTH-1:0]        ENV_MAX = ENV_WIDTH'(2 ** (FRAC + 1));

	function automatic logic signed [PROD_WIDTH-1:0] round_shift(
		input logic signed [PROD_WIDTH-1:0] v,
		input int                           n
	);
		logic signed [PROD_WIDTH-1:0] half;
		half = (n > 0) ? (PROD_WIDTH'(1) <<< (n - 1)) : '0;
		return (v + half) >>> n;
	endfunction

	state_t                         state_q;
	logic [COEF_WIDTH-1:0]          attack_q;
	logic [COEF_WIDTH-1:0]          release_q;
	logic signed [GAIN_WIDTH-1:0]   gain_q;
	logic signed [SAMPLE_WIDTH-1:0] dli_q;
	logic signed [DC_WIDTH-1:0]     dlo_q;
	logic [ENV_WIDTH-1:0]           env_q;
	logic                           out_valid_q;

	logic signed [SAMPLE_WIDTH-1:0] x_q;
	logic [ENV_WIDTH-1:0]           mag_q;
	logic [LEVEL_WIDTH-1:0]         lvl_q;
	logic [LEVEL_WIDTH-1:0]         envelope_level_q;
	logic signed [MOD_WIDTH-1:0]    modulation_amount_q;

	mul_req_t                       mul_req;
	logic signed [PROD_WIDTH-1:0]   prod_q;

	logic signed [PROD_WIDTH-1:0]   pole_term;
	logic signed [SUM_WIDTH-1:0]    y_sum;
	logic signed [DC_WIDTH-1:0]     y_sat;
	logic signed [DC_WIDTH-1:0]     y_neg;
	logic [ENV_WIDTH-1:0]           mag;
	logic signed [DC_WIDTH-1:0]     env_diff;
	logic [COEF_WIDTH-1:0]          coef;
	logic signed [PROD_WIDTH-1:0]   coef_term;
	logic signed [SUM_WIDTH-1:0]    env_sum;
	logic [ENV_WIDTH-1:0]           env_next;
	logic signed [PROD_WIDTH-1:0]   lvl_wide;
	logic [LEVEL_WIDTH-1:0]         lvl_next;
	logic signed [PROD_WIDTH-1:0]   mod_wide;
	logic                           sample_fire;
	logic                           emit_fire;

	assign sample_ready      = (state_q == IDLE);
	assign sample_fire       = sample_valid && sample_ready;
	assign emit_fire         = (state_q == EMIT) && (!out_valid_q || out_ready);
	assign out_valid         = out_valid_q;
	assign envelope_level    = envelope_level_q;
	assign modulation_amount = modulation_amount_q;

	// DC blocker: x - x_prev + pole * y_prev, saturated to +-2.0
	always_comb begin
		pole_term = round_shift(prod_q, POLE_SHIFT);
		y_sum     = SUM_WIDTH'(x_q) - SUM_WIDTH'(dli_q) + $signed(pole_term[SUM_WIDTH-1:0]);
		if (y_sum > SUM_POS) begin
			y_sat = DC_POS;
		end else if (y_sum < SUM_NEG) begin
			y_sat = DC_NEG;
		end else begin
			y_sat = $signed(y_sum[DC_WIDTH-1:0]);
		end
		y_neg = -y_sat;
		mag   = (y_sat < 0) ? y_neg[ENV_WIDTH-1:0] : y_sat[ENV_WIDTH-1:0];
	end

	// follower: attack while rising, release otherwise
	always_comb begin
		env_diff  = $signed({1'b0, env_q}) - $signed({1'b0, mag_q});
		coef      = (mag_q > env_q) ? attack_q : release_q;
		coef_term = round_shift(prod_q, COEF_SHIFT);
		env_sum   = $signed(SUM_WIDTH'({1'b0, mag_q})) + $signed(coef_term[SUM_WIDTH-1:0]);
		if (env_sum < 0) begin
			env_next = '0;
		end else if (env_sum > SUM_POS) begin
			env_next = ENV_MAX;
		end else begin
			env_next = env_sum[ENV_WIDTH-1:0];
		end
	end

	// level in Q4.11 and the gain product
	always_comb begin
		lvl_wide = round_shift(prod_q, LVL_RSH) <<< LVL_LSH;
		if (lvl_wide > LEVEL_MAX) begin
			lvl_next = LEVEL_WIDTH'(LEVEL_MAX);
		end else if (lvl_wide < 0) begin
			lvl_next = '0;
		end else begin
			lvl_next = lvl_wide[LEVEL_WIDTH-1:0];
		end
		mod_wide = round_shift(prod_q, GAIN_SHIFT);
	end

	// operand select for the shared multiplier
	always_comb begin
		mul_req = '0;
		case (state_q)
			MUL_POLE: begin
				mul_req.en = 1'b1;
				mul_req.a  = MUL_A_WIDTH'(dlo_q);
				mul_req.b  = MUL_B_WIDTH'(POLE_Q16);
			end
			MUL_ENV: begin
				mul_req.en = 1'b1;
				mul_req.a  = MUL_A_WIDTH'(env_diff);
				mul_req.b  = $signed({1'b0, coef});
			end
			MUL_LVL: begin
				mul_req.en = 1'b1;
				mul_req.a  = $signed(MUL_A_WIDTH'({1'b0, env_q}));
				mul_req.b  = MUL_B_WIDTH'(LEVEL_SCALE);
			end
			MUL_GAIN: begin
				mul_req.en = 1'b1;
				mul_req.a  = MUL_A_WIDTH'(gain_q);
				mul_req.b  = $signed(MUL_B_WIDTH'(lvl_q));
			end
			default: begin
				mul_req = '0;
			end
		endcase
	end

	dcbef_mul u_mul (
		.clk    (clk),
		.req    (mul_req),
		.prod_q (prod_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			attack_q    <= '0;
			release_q   <= '0;
			gain_q      <= '0;
			dli_q       <= '0;
			dlo_q       <= '0;
			env_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_ATTACK_COEF:  attack_q  <= cfg_wdata[COEF_WIDTH-1:0];
					REG_RELEASE_COEF: release_q <= cfg_wdata[COEF_WIDTH-1:0];
					REG_GAIN:         gain_q    <= $signed(cfg_wdata[GAIN_WIDTH-1:0]);
					default:          ;
				endcase
			end
			if (emit_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				IDLE: begin
					if (sample_valid) begin
						state_q <= MUL_POLE;
					end
				end
				MUL_POLE: state_q <= BLOCK;
				BLOCK: begin
					dli_q   <= x_q;
					dlo_q   <= y_sat;
					state_q <= MUL_ENV;
				end
				MUL_ENV: state_q <= ENV;
				ENV: begin
					env_q   <= env_next;
					state_q <= MUL_LVL;
				end
				MUL_LVL:  state_q <= LEVEL;
				LEVEL:    state_q <= MUL_GAIN;
				MUL_GAIN: state_q <= EMIT;
				EMIT: begin
					// hold until the output register is free
					if (emit_fire) begin
						state_q <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (sample_fire) begin
			x_q <= sample_in;
		end
		if (state_q == BLOCK) begin
			mag_q <= mag;
		end
		if (state_q == LEVEL) begin
			lvl_q <= lvl_next;
		end
		if (emit_fire) begin
			envelope_level_q    <= lvl_q;
			modulation_amount_q <= mod_wide[MOD_WIDTH-1:0];
		end
	end

	`DCBEF_ASSERT_ALWAYS(env_in_range_a, env_q <= ENV_MAX, "envelope above 2.0")
	`DCBEF_ASSERT_ALWAYS(dlo_in_range_a, (dlo_q <= DC_POS) && (dlo_q >= DC_NEG),
		"blocker state out of range")
	`DCBEF_ASSERT_IMPL(level_in_range_a, out_valid_q, envelope_level_q <= LEVEL_MAX, "level above 10.0")
	`DCBEF_ASSERT_NEXT(busy_after_transfer_a, sample_fire, !sample_ready, "ready right after a transfer")
	`DCBEF_ASSERT_NEXT(emit_holds_a, (state_q == EMIT) && out_valid_q && !out_ready,
		state_q == EMIT, "result dropped while output stalled")

endmodule
